// ----- rtl/dtw_pkg.sv -----
// ----------------------------------------------------------------------------
// dtw_pkg
// Shared types, codes and sizes for the trajectory distance block.
// ----------------------------------------------------------------------------
package dtw_pkg;

  localparam int unsigned MAX_POINTS_DEF = 64;
  localparam int unsigned MAX_DIMS_DEF   = 4;
  localparam int unsigned COORD_BITS_DEF = 16;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned NUM_COORD = 4;
  localparam int unsigned DIST_W    = 40;
  localparam int unsigned FRAC_SH   = 16;
  localparam int unsigned DIMS_W    = 3;
  localparam int unsigned DIMS_RST  = 2;
  localparam int unsigned APB_W     = 32;
  localparam int unsigned ADDR_W    = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    FUNC_APPEND_A = 2'd0,
    FUNC_APPEND_B = 2'd1,
    FUNC_COMPUTE  = 2'd2,
    FUNC_NONE     = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISSING  = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_CAPACITY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ACC,
    S_ROOT,
    S_WAIT,
    S_UPD
  } state_t;

  localparam logic [ADDR_W-1:0] REG_DIMS = 2'd0;

endpackage

// ----- rtl/dtw_ram.sv -----
// ----------------------------------------------------------------------------
// dtw_ram
// Simple dual-port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module dtw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/dtw_sqrt.sv -----
// ----------------------------------------------------------------------------
// dtw_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module dtw_sqrt #(
  parameter int unsigned ROOTW = 26
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*ROOTW-1:0] radicand,
  output logic               done,
  output logic [ROOTW-1:0]   root
);

  localparam int unsigned CW = $clog2(ROOTW + 1);

  logic [2*ROOTW-1:0] x_r, x_nxt;
  logic [ROOTW+1:0]   rem_r, rem_nxt;
  logic [ROOTW-1:0]   root_r, root_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [ROOTW+1:0]   shifted;
  logic [ROOTW+1:0]   trial;

  always_comb begin
    shifted  = {rem_r[ROOTW-1:0], x_r[2*ROOTW-1 -: 2]};
    trial    = {root_r, 2'b01};
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CW'(ROOTW);
    end else if (cnt_r != '0) begin
      x_nxt   = {x_r[2*ROOTW-3:0], 2'b00};
      cnt_nxt = cnt_r - 1'b1;
      if (shifted >= trial) begin
        rem_nxt  = shifted - trial;
        root_nxt = {root_r[ROOTW-2:0], 1'b1};
      end else begin
        rem_nxt  = shifted;
        root_nxt = {root_r[ROOTW-2:0], 1'b0};
      end
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/dtw_trajectory_distance.sv -----
// ----------------------------------------------------------------------------
// dtw_trajectory_distance
// Dynamic time warping distance between two stored point trajectories.
//
// Channel  | Handshake               | Payload
// input    | start, busy             | in_func, in_coord_0..in_coord_3
// result   | out_valid (one cycle)   | out_distance, out_status
// config   | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// An append never raises busy. A compute with an error status answers in the
// next cycle. Otherwise each matrix cell steps through a read, then a multiply
// and an accumulate for each dimension in use, then the bit-serial square root
// and the update; the whole compute takes count_a*count_b cells.
// Reset is synchronous; no clearing pass is needed. busy is high during a
// compute; the result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module dtw_trajectory_distance #(
  parameter int unsigned MAX_POINTS = dtw_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_DIMS   = dtw_pkg::MAX_DIMS_DEF,
  parameter int unsigned COORD_BITS = dtw_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic [dtw_pkg::FIELD_W-1:0]   in_coord_0,
  input  logic [dtw_pkg::FIELD_W-1:0]   in_coord_1,
  input  logic [dtw_pkg::FIELD_W-1:0]   in_coord_2,
  input  logic [dtw_pkg::FIELD_W-1:0]   in_coord_3,
  output logic                          out_valid,
  output logic [dtw_pkg::DIST_W-1:0]    out_distance,
  output logic [1:0]                    out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtw_pkg::ADDR_W-1:0]    paddr,
  input  logic [dtw_pkg::APB_W-1:0]     pwdata,
  output logic [dtw_pkg::APB_W-1:0]     prdata,
  output logic                          pready
);

  import dtw_pkg::*;

  localparam int unsigned IDXW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CNTW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned DIMW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned PW    = MAX_DIMS * COORD_BITS;
  localparam int unsigned SQW   = 2 * COORD_BITS + 2;
  localparam int unsigned SUMW  = 2 * COORD_BITS + 4;
  localparam int unsigned ROOTW = COORD_BITS + 10;

  state_t state_r, state_nxt;

  logic [DIMS_W-1:0]   dims_in_use_r;
  logic [CNTW-1:0]     cnt_a_r, cnt_b_r, na_r, nb_r;
  logic [MAX_DIMS-1:0] miss_r;
  logic                cap_r;
  logic [IDXW-1:0]     i_r, j_r;
  logic [DIMW-1:0]     c_r, dlast_r, dlast_now;
  logic [SQW-1:0]      sq_r;
  logic [SUMW-1:0]     sum_r;
  logic [DIST_W-1:0]   left_r, diag_r;
  logic                out_valid_r;
  logic [DIST_W-1:0]   out_distance_r;
  status_t             out_status_r;

  logic                accept, cfg_wr;
  logic [FIELD_W-1:0]  coords [NUM_COORD];
  logic [PW-1:0]       point_in;
  logic [MAX_DIMS-1:0] miss_in, dmask;
  logic                wr_a, wr_b, full_a, full_b, miss_any;
  logic                rd_en, mul_en, acc_en, root_start, upd_en;
  logic                row_last, col_last;
  logic [PW-1:0]       pa_rd, pb_rd;
  logic [DIST_W-1:0]   up_rd, up_sel, best, cell_val;
  logic [DIST_W:0]     add_full;
  logic                root_done;
  logic [ROOTW-1:0]    root_val;
  logic signed [COORD_BITS:0] diff;
  logic signed [SQW-1:0]      sq_full;
  logic [2*ROOTW-1:0]  radicand;

  assign accept = start && !busy;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = {{(APB_W-DIMS_W){1'b0}}, dims_in_use_r};
  assign busy   = (state_r != S_IDLE);

  always_comb begin
    coords[0] = in_coord_0;
    coords[1] = in_coord_1;
    coords[2] = in_coord_2;
    coords[3] = in_coord_3;
    point_in  = '0;
    miss_in   = '0;
    for (int c = 0; c < MAX_DIMS; c++) begin
      point_in[c*COORD_BITS +: COORD_BITS] = coords[c][COORD_BITS-1:0];
      miss_in[c] = &coords[c][COORD_BITS-1:0];
    end
  end

  always_comb begin
    if (dims_in_use_r == '0) begin
      dlast_now = '0;
    end else if (dims_in_use_r > DIMS_W'(MAX_DIMS)) begin
      dlast_now = DIMW'(MAX_DIMS - 1);
    end else begin
      dlast_now = DIMW'(dims_in_use_r - 1'b1);
    end
    for (int c = 0; c < MAX_DIMS; c++) begin
      dmask[c] = (DIMW'(c) <= dlast_now);
    end
    miss_any = |(miss_r & dmask);
  end

  assign full_a = (cnt_a_r >= CNTW'(MAX_POINTS));
  assign full_b = (cnt_b_r >= CNTW'(MAX_POINTS));
  assign wr_a   = accept && (in_func == FUNC_APPEND_A) && !full_a;
  assign wr_b   = accept && (in_func == FUNC_APPEND_B) && !full_b;

  dtw_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS), .AW(IDXW)) u_points_a (
    .clk     (clk),
    .wr_en   (wr_a),
    .wr_addr (cnt_a_r[IDXW-1:0]),
    .wr_data (point_in),
    .rd_en   (rd_en),
    .rd_addr (i_r),
    .rd_data (pa_rd)
  );

  dtw_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS), .AW(IDXW)) u_points_b (
    .clk     (clk),
    .wr_en   (wr_b),
    .wr_addr (cnt_b_r[IDXW-1:0]),
    .wr_data (point_in),
    .rd_en   (rd_en),
    .rd_addr (j_r),
    .rd_data (pb_rd)
  );

  dtw_ram #(.WIDTH(DIST_W), .DEPTH(MAX_POINTS), .AW(IDXW)) u_warp_row (
    .clk     (clk),
    .wr_en   (upd_en),
    .wr_addr (j_r),
    .wr_data (cell_val),
    .rd_en   (rd_en),
    .rd_addr (j_r),
    .rd_data (up_rd)
  );

  assign diff    = $signed({pa_rd[c_r*COORD_BITS + COORD_BITS - 1], pa_rd[c_r*COORD_BITS +: COORD_BITS]})
                 - $signed({pb_rd[c_r*COORD_BITS + COORD_BITS - 1], pb_rd[c_r*COORD_BITS +: COORD_BITS]});
  assign sq_full = diff * diff;
  assign radicand = (2*ROOTW)'({sum_r, {FRAC_SH{1'b0}}});

  dtw_sqrt #(.ROOTW(ROOTW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root_val)
  );

  always_comb begin
    up_sel   = (i_r == '0) ? DIST_MAX : up_rd;
    best     = (up_sel < left_r) ? up_sel : left_r;
    best     = (diag_r < best) ? diag_r : best;
    add_full = {1'b0, best} + {{(DIST_W+1-ROOTW){1'b0}}, root_val};
    cell_val = add_full[DIST_W] ? DIST_MAX : add_full[DIST_W-1:0];
    row_last = (CNTW'(i_r) == na_r - 1'b1);
    col_last = (CNTW'(j_r) == nb_r - 1'b1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_func == FUNC_COMPUTE) && !cap_r && (cnt_a_r != '0)
            && (cnt_b_r != '0) && !miss_any) begin
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ACC;
      S_ACC:  state_nxt = (c_r == dlast_r) ? S_ROOT : S_MUL;
      S_ROOT: state_nxt = S_WAIT;
      S_WAIT: state_nxt = root_done ? S_UPD : S_WAIT;
      S_UPD:  state_nxt = (row_last && col_last) ? S_IDLE : S_READ;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    mul_en     = 1'b0;
    acc_en     = 1'b0;
    root_start = 1'b0;
    upd_en     = 1'b0;
    unique case (state_r)
      S_READ: rd_en      = 1'b1;
      S_MUL:  mul_en     = 1'b1;
      S_ACC:  acc_en     = 1'b1;
      S_ROOT: root_start = 1'b1;
      S_UPD:  upd_en     = 1'b1;
      S_IDLE, S_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      dims_in_use_r <= DIMS_W'(DIMS_RST);
      cnt_a_r       <= '0;
      cnt_b_r       <= '0;
      miss_r        <= '0;
      cap_r         <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (accept && (in_func == FUNC_COMPUTE)
                      && (cap_r || (cnt_a_r == '0) || (cnt_b_r == '0) || miss_any))
                     || (upd_en && row_last && col_last);
      if (cfg_wr && (paddr == REG_DIMS)) begin
        dims_in_use_r <= pwdata[DIMS_W-1:0];
      end
      if (wr_a) begin
        cnt_a_r <= cnt_a_r + 1'b1;
        miss_r  <= miss_r | miss_in;
      end
      if (wr_b) begin
        cnt_b_r <= cnt_b_r + 1'b1;
        miss_r  <= miss_r | miss_in;
      end
      if (accept && (((in_func == FUNC_APPEND_A) && full_a)
                     || ((in_func == FUNC_APPEND_B) && full_b))) begin
        cap_r <= 1'b1;
      end
      if (accept && (in_func == FUNC_COMPUTE)) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
        miss_r  <= '0;
        cap_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_func == FUNC_COMPUTE)) begin
      na_r           <= cnt_a_r;
      nb_r           <= cnt_b_r;
      dlast_r        <= dlast_now;
      i_r            <= '0;
      j_r            <= '0;
      left_r         <= DIST_MAX;
      diag_r         <= '0;
      out_distance_r <= '0;
      if (cap_r) begin
        out_status_r <= STAT_CAPACITY;
      end else if ((cnt_a_r == '0) || (cnt_b_r == '0)) begin
        out_status_r <= STAT_EMPTY;
      end else if (miss_any) begin
        out_status_r <= STAT_MISSING;
      end else begin
        out_status_r <= STAT_OK;
      end
    end
    if (rd_en) begin
      c_r   <= '0;
      sum_r <= '0;
    end
    if (mul_en) begin
      sq_r <= sq_full;
    end
    if (acc_en) begin
      sum_r <= sum_r + SUMW'(sq_r);
      c_r   <= c_r + 1'b1;
    end
    if (upd_en) begin
      if (col_last) begin
        i_r    <= i_r + 1'b1;
        j_r    <= '0;
        left_r <= DIST_MAX;
        diag_r <= DIST_MAX;
      end else begin
        j_r    <= j_r + 1'b1;
        left_r <= cell_val;
        diag_r <= up_sel;
      end
      if (row_last && col_last) begin
        out_distance_r <= cell_val;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_status   = out_status_r;

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_OK)) |-> (out_distance_r == '0))
    else $error("Error status with a nonzero distance.");

  a_root_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> (state_r == S_WAIT))
    else $error("Square root finished outside the wait state.");

  a_upd_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |=> ((state_r == S_READ) || (state_r == S_IDLE)))
    else $error("Unexpected state after a cell update.");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $past(upd_en && row_last && col_last) |-> (out_valid_r && (state_r == S_IDLE)))
    else $error("Final cell did not produce a transaction.");

endmodule

// ----- sim/tb_dtw_trajectory_distance.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dtw_trajectory_distance
// Self-checking testbench for the trajectory distance block. Trajectories are
// loaded with directed and random points, the dimension register is swept,
// and every emitted distance and status is checked against a behavioral
// dynamic time warping calculation.
// ----------------------------------------------------------------------------
module tb_dtw_trajectory_distance;
  import dtw_pkg::*;

  localparam int unsigned NPTS     = MAX_POINTS_DEF;
  localparam int unsigned WATCHDOG = 200000;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_func;
  logic [FIELD_W-1:0]   in_coord_0;
  logic [FIELD_W-1:0]   in_coord_1;
  logic [FIELD_W-1:0]   in_coord_2;
  logic [FIELD_W-1:0]   in_coord_3;
  logic                 out_valid;
  logic [DIST_W-1:0]    out_distance;
  logic [1:0]           out_status;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [APB_W-1:0]     pwdata;
  logic [APB_W-1:0]     prdata;
  logic                 pready;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } dtw_result_t;

  logic [63:0]       traj_a [NPTS];
  logic [63:0]       traj_b [NPTS];
  int unsigned       len_a;
  int unsigned       len_b;
  logic              overflow_flag;
  logic [DIMS_W-1:0] dims_reg;
  logic [DIST_W-1:0] warp_line [NPTS+1];

  dtw_result_t expected_results [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          timed_out;
  bit          start_held;

  dtw_trajectory_distance DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_coord_0(in_coord_0), .in_coord_1(in_coord_1),
    .in_coord_2(in_coord_2), .in_coord_3(in_coord_3),
    .out_valid(out_valid), .out_distance(out_distance), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned active_dims();
    int unsigned d;
    d = dims_reg;
    if (d == 0) d = 1;
    if (d > MAX_DIMS_DEF) d = MAX_DIMS_DEF;
    return d;
  endfunction

  function automatic logic [DIST_W-1:0] point_cost(logic [63:0] p, logic [63:0] q,
                                                   int unsigned d);
    logic [63:0] sum;
    longint      diff;
    sum = 0;
    for (int c = 0; c < d; c++) begin
      diff = longint'($signed(p[16*c +: 16])) - longint'($signed(q[16*c +: 16]));
      if (diff < 0) diff = -diff;
      sum = sum + 64'(diff * diff);
    end
    return DIST_W'(int_sqrt(sum << FRAC_SH));
  endfunction

  function automatic logic [DIST_W-1:0] add_sat(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
  endfunction

  function automatic bit point_missing(logic [63:0] p, int unsigned d);
    for (int c = 0; c < d; c++)
      if (p[16*c +: 16] == 16'hFFFF) return 1'b1;
    return 1'b0;
  endfunction

  task automatic predict_distance(input func_t f, input logic [63:0] pt);
    dtw_result_t r;
    int unsigned d;
    bit          miss;
    logic [DIST_W-1:0] diag, up, best;
    if (f == FUNC_APPEND_A || f == FUNC_APPEND_B) begin
      if (f == FUNC_APPEND_A) begin
        if (len_a < NPTS) begin
          traj_a[len_a] = pt;
          len_a++;
        end else begin
          overflow_flag = 1'b1;
        end
      end else begin
        if (len_b < NPTS) begin
          traj_b[len_b] = pt;
          len_b++;
        end else begin
          overflow_flag = 1'b1;
        end
      end
      return;
    end
    if (f != FUNC_COMPUTE) return;
    d = active_dims();
    miss = 0;
    for (int i = 0; i < len_a; i++) if (point_missing(traj_a[i], d)) miss = 1;
    for (int i = 0; i < len_b; i++) if (point_missing(traj_b[i], d)) miss = 1;
    r.distance = '0;
    if (overflow_flag) r.status = STAT_CAPACITY;
    else if (len_a == 0 || len_b == 0) r.status = STAT_EMPTY;
    else if (miss) r.status = STAT_MISSING;
    else begin
      r.status = STAT_OK;
      warp_line[0] = '0;
      for (int j = 1; j <= len_b; j++) warp_line[j] = DIST_MAX;
      for (int i = 0; i < len_a; i++) begin
        diag = warp_line[0];
        warp_line[0] = DIST_MAX;
        for (int j = 1; j <= len_b; j++) begin
          up = warp_line[j];
          best = up < warp_line[j-1] ? up : warp_line[j-1];
          if (diag < best) best = diag;
          warp_line[j] = add_sat(best, point_cost(traj_a[i], traj_b[j-1], d));
          diag = up;
        end
      end
      r.distance = warp_line[len_b];
    end
    expected_results.push_back(r);
    len_a = 0;
    len_b = 0;
    overflow_flag = 0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result distance=%h status=%0d",
                   out_distance, out_status);
      end else begin
        dtw_result_t e;
        e = expected_results.pop_front();
        if (out_distance !== e.distance || out_status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected distance=%h status=%0d, got distance=%h status=%0d",
                     e.distance, e.status, out_distance, out_status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("dtw_trajectory_distance test failed");
      $finish;
    end
  end

  function automatic int unsigned gap_length();
    int unsigned n;
    n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 30);
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  task automatic release_start();
    if (start_held) begin
      start <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  task automatic send_item(input func_t f, input logic [15:0] c0, input logic [15:0] c1,
                           input logic [15:0] c2, input logic [15:0] c3);
    int unsigned n;
    in_func    <= f;
    in_coord_0 <= c0;
    in_coord_1 <= c1;
    in_coord_2 <= c2;
    in_coord_3 <= c3;
    start      <= 1'b1;
    start_held = 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_distance(f, {c3, c2, c1, c0});
    n = gap_length();
    if (n == 0) begin
      start_held = 1'b1;
    end else begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_dims(input logic [DIMS_W-1:0] v);
    release_start();
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DIMS;
    pwdata  <= APB_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    dims_reg = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord(bit narrow);
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'hFFFF;
    if (k == 1) return 16'h8000;
    if (k == 2) return 16'h7FFF;
    if (narrow) return 16'($signed($urandom_range(0, 400)) - 200);
    return 16'($urandom);
  endfunction

  task automatic send_point(input func_t f, input bit narrow);
    logic [15:0] c [4];
    for (int i = 0; i < 4; i++) begin
      c[i] = rand_coord(narrow);
      if (c[i] == 16'hFFFF && $urandom_range(0, 3) != 0) c[i] = 16'h0000;
    end
    send_item(f, c[0], c[1], c[2], c[3]);
  endtask

  task automatic test_directed();
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    send_item(FUNC_APPEND_A, 16'h0003, 16'h0004, 0, 0);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    send_item(FUNC_APPEND_A, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(FUNC_APPEND_B, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_item(FUNC_APPEND_B, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    send_item(FUNC_APPEND_A, 16'h0001, 16'hFFFF, 0, 0);
    send_item(FUNC_APPEND_B, 16'h0002, 16'h0002, 0, 0);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    send_item(FUNC_APPEND_A, 16'h0001, 16'h0002, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_APPEND_B, 16'h0005, 16'h0006, 16'h0001, 16'h0001);
    send_item(FUNC_NONE, 16'hFFFF, 16'h1234, 16'h5678, 16'h9ABC);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
  endtask

  task automatic test_capacity();
    for (int i = 0; i < NPTS + 1; i++) send_point(FUNC_APPEND_A, 1);
    send_point(FUNC_APPEND_B, 1);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
    for (int i = 0; i < NPTS; i++) send_point(FUNC_APPEND_B, 1);
    send_point(FUNC_APPEND_A, 1);
    send_item(FUNC_COMPUTE, 0, 0, 0, 0);
  endtask

  task automatic test_dims_sweep();
    logic [DIMS_W-1:0] settings [6] = '{3'd0, 3'd1, 3'd4, 3'd7, 3'd3, 3'd5};
    foreach (settings[s]) begin
      write_dims(settings[s]);
      for (int k = 0; k < 3; k++) begin
        repeat ($urandom_range(1, 4)) send_point(FUNC_APPEND_A, k != 0);
        repeat ($urandom_range(1, 4)) send_point(FUNC_APPEND_B, k != 0);
        send_item(FUNC_COMPUTE, 0, 0, 0, 0);
      end
    end
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned na, nb;
    sent = 0;
    while (sent < 300) begin
      if ($urandom_range(0, 9) == 0) write_dims(DIMS_W'($urandom_range(0, 7)));
      if ($urandom_range(0, 9) < 8) begin
        na = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        nb = $urandom_range(1, 6);
        for (int i = 0; i < na + nb; i++) begin
          if ($urandom_range(0, 1)) begin
            if (na > 0) begin send_point(FUNC_APPEND_A, $urandom_range(0, 1)); na--; end
            else begin send_point(FUNC_APPEND_B, $urandom_range(0, 1)); nb--; end
          end else begin
            if (nb > 0) begin send_point(FUNC_APPEND_B, $urandom_range(0, 1)); nb--; end
            else begin send_point(FUNC_APPEND_A, $urandom_range(0, 1)); na--; end
          end
          sent++;
        end
      end else begin
        send_item(func_t'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
        sent++;
      end
      send_item(FUNC_COMPUTE, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      sent++;
    end
  endtask

  initial begin
    clk = 0;
    rst_n = 0;
    start = 0;
    in_func = FUNC_NONE;
    in_coord_0 = '0;
    in_coord_1 = '0;
    in_coord_2 = '0;
    in_coord_3 = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = REG_DIMS;
    pwdata = '0;
    len_a = 0;
    len_b = 0;
    overflow_flag = 0;
    dims_reg = DIMS_RST;
    mismatches = 0;
    idle_cycles = 0;
    timed_out = 0;
    start_held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_dims_sweep();
    test_random();
    release_start();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("dtw_trajectory_distance test passed");
    else
      $display("dtw_trajectory_distance test failed");
    $finish;
  end

endmodule
